// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the frequency table RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge while out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that an expression never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/core/ftq_pkg.sv =====
// Package for the frequency table query engine: sizes, command codes,
// and the control/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ftq_pkg;

  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 10;

  localparam int CMD_W = 2;
  localparam int KEY_W = 10;
  localparam int THR_W = 10;

  localparam int KEY_SPACE   = 1 << KEY_BITS;
  localparam int COUNT_SPACE = 1 << COUNT_BITS;
  // keys_per_count entries must hold KEY_SPACE itself
  localparam int KPC_BITS    = KEY_BITS + 1;
  localparam int CLR_BITS    = (KEY_BITS > COUNT_BITS) ? KEY_BITS : COUNT_BITS;
  localparam int CMP_BITS    = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  localparam int IN_BITS     = CMD_W + KEY_W + THR_W;
  localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam logic [CLR_BITS-1:0]   CLR_LAST  = '1;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [KEY_W-1:0] key;
    logic [CMD_W-1:0] command;
  } ftq_in_t;

  typedef struct packed {
    logic clr_en;      // clearing pass write
    logic load_in;     // latch update command, read key count
    logic rd_kpc;      // read both keys_per_count entries
    logic wr1;         // write key count, old count entry, largest
    logic wr2;         // write new count entry
    logic load_found;  // evaluate a check into the output register
  } ftq_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ftq_sts_t;

endpackage

// ===== rtl/core/ftq_ctrl.sv =====
// Controller state machine of the frequency table query engine.
// Depends on ftq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftq_ctrl import ftq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic [CMD_W-1:0] s_cmd_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  ftq_sts_t         sts_i,
  output ftq_cmd_t         cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDCNT = 3'd2;
  localparam logic [2:0] ST_RDKPC = 3'd3;
  localparam logic [2:0] ST_WR2   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       is_upd;
  logic       accept;

  assign is_upd    = (s_cmd_i == CMD_ADD) || (s_cmd_i == CMD_REMOVE);
  // an update needs no output slot; a check needs a free or draining one
  assign s_ready_o = (state_q == ST_IDLE) && (is_upd || !m_valid_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (accept && is_upd) state_d = ST_RDCNT;
      ST_RDCNT: state_d = ST_RDKPC;
      ST_RDKPC: state_d = ST_WR2;
      ST_WR2:   state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (accept && !is_upd) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.clr_en     = (state_q == ST_CLEAR);
    cmd_o.load_in    = accept && is_upd;
    cmd_o.rd_kpc     = (state_q == ST_RDCNT);
    cmd_o.wr1        = (state_q == ST_RDKPC);
    cmd_o.wr2        = (state_q == ST_WR2);
    cmd_o.load_found = accept && !is_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  `ASSERT_PROP(a_upd_starts, clk_i, rst_ni, (accept && is_upd) |=> (state_q == ST_RDCNT), "update did not start")
  `ASSERT_PROP(a_chk_result, clk_i, rst_ni, (accept && !is_upd) |=> m_valid_q, "check gave no result")
  `ASSERT_PROP(a_clr_holds, clk_i, rst_ni, ((state_q == ST_CLEAR) && !sts_i.clr_last) |=> (state_q == ST_CLEAR), "clearing pass cut short")
  `ASSERT_PROP(a_wr_order, clk_i, rst_ni, cmd_o.wr2 |-> $past(cmd_o.wr1), "second write out of order")

endmodule

// ===== rtl/core/ftq_dpath.sv =====
// Datapath of the frequency table query engine: count and keys-per-count
// memories, largest count, clear counter, result register. Depends on ftq_pkg.
`timescale 1ns / 1ps

module ftq_dpath import ftq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ftq_cmd_t         cmd_i,
  input  logic [CMD_W-1:0] s_cmd_i,
  input  logic [KEY_W-1:0] s_key_i,
  input  logic [THR_W-1:0] s_thr_i,
  output logic             found_o,
  output ftq_sts_t         sts_o
);

  logic [COUNT_BITS-1:0] kc_mem  [KEY_SPACE];
  logic [KPC_BITS-1:0]   kpc_mem [COUNT_SPACE];

  logic                  op_add_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [KPC_BITS-1:0]   kpc_a_q, kpc_b_q;
  logic [COUNT_BITS-1:0] largest_q, largest_d;
  logic [CLR_BITS-1:0]   clr_q;
  logic                  found_q;

  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  do_upd;
  logic                  kc_we;
  logic [KEY_BITS-1:0]   kc_waddr;
  logic [COUNT_BITS-1:0] kc_wdata;
  logic                  kpc_we;
  logic [COUNT_BITS-1:0] kpc_waddr;
  logic [KPC_BITS-1:0]   kpc_wdata;

  assign rd_key  = KEY_BITS'(s_key_i);
  assign cnt_new = op_add_q ? (cnt_q + COUNT_BITS'(1)) : (cnt_q - COUNT_BITS'(1));
  // saturated add and remove at zero change nothing
  assign do_upd  = op_add_q ? (cnt_q != COUNT_TOP) : (cnt_q != '0);

  always_comb begin
    kc_we    = cmd_i.clr_en || (cmd_i.wr1 && do_upd);
    kc_waddr = cmd_i.clr_en ? KEY_BITS'(clr_q) : key_q;
    kc_wdata = cmd_i.clr_en ? '0 : cnt_new;
  end

  // count zero has no entry: skip the old slot for zero, the new slot for zero
  always_comb begin
    kpc_we    = 1'b0;
    kpc_waddr = COUNT_BITS'(clr_q);
    kpc_wdata = '0;
    if (cmd_i.clr_en) begin
      kpc_we = 1'b1;
    end else if (cmd_i.wr1) begin
      kpc_we    = do_upd && (cnt_q != '0);
      kpc_waddr = cnt_q;
      kpc_wdata = kpc_a_q - KPC_BITS'(1);
    end else if (cmd_i.wr2) begin
      kpc_we    = do_upd && (cnt_new != '0);
      kpc_waddr = cnt_new;
      kpc_wdata = kpc_b_q + KPC_BITS'(1);
    end
  end

  always_comb begin
    largest_d = largest_q;
    if (cmd_i.wr1 && do_upd) begin
      if (op_add_q) begin
        if (cnt_new > largest_q) largest_d = cnt_new;
      end else if ((cnt_q == largest_q) && (kpc_a_q == KPC_BITS'(1))) begin
        largest_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (kc_we) kc_mem[kc_waddr] <= kc_wdata;
    if (cmd_i.load_in) cnt_q <= kc_mem[rd_key];
  end

  always_ff @(posedge clk_i) begin
    if (kpc_we) kpc_mem[kpc_waddr] <= kpc_wdata;
    if (cmd_i.rd_kpc) begin
      kpc_a_q <= kpc_mem[cnt_q];
      kpc_b_q <= kpc_mem[cnt_new];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_add_q <= (s_cmd_i == CMD_ADD);
      key_q    <= rd_key;
    end
    if (cmd_i.load_found) begin
      found_q <= (largest_q != '0) && (CMP_BITS'(largest_q) >= CMP_BITS'(s_thr_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q <= '0;
      clr_q     <= '0;
    end else begin
      largest_q <= largest_d;
      if (cmd_i.clr_en) clr_q <= clr_q + CLR_BITS'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == CLR_LAST);
  assign found_o        = found_q;

endmodule

// ===== rtl/core/frequency_table_query_engine.sv =====
// Top level of the frequency table query engine: stream ports, controller
// and datapath. Depends on ftq_pkg, ftq_ctrl and ftq_dpath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid_i/tready_o   command, key, threshold
// m_axis    out        m_axis_tvalid_o/tready_i   found
//
// A check is evaluated against the largest count at acceptance and lands
// in the output register. An add or remove steps through RDCNT, RDKPC and
// WR2: the read-modify-write of the count memory followed by two
// writes through the single write port of the keys-per-count memory.
// After reset a clearing pass zeroes both memories, one entry per cycle;
// no transaction is accepted then.
// Updates are accepted while a check result waits; a check waits for the
// output register to free up.

module frequency_table_query_engine import ftq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [1:0] command, [11:2] key, [21:12] threshold, [23:22] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [0] found, [7:1] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  ftq_in_t  in_item;
  ftq_cmd_t cmd;
  ftq_sts_t sts;
  logic     found;

  // unpack the input transaction
  assign in_item = ftq_in_t'(s_axis_tdata_i[IN_BITS-1:0]);

  ftq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_cmd_i   (in_item.command),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ftq_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .s_cmd_i (in_item.command),
    .s_key_i (in_item.key),
    .s_thr_i (in_item.threshold),
    .found_o (found),
    .sts_o   (sts)
  );

  // pad the result to a whole byte
  assign m_axis_tdata_o = {{(M_TDATA_W-1){1'b0}}, found};

endmodule

// ===== tb/frequency_table_query_engine_tb.sv =====
// Self-checking testbench for frequency_table_query_engine: directed table, random
// add/remove/check traffic with an in-bench count predictor, and a saturate-and-drain pass.
// Depends on ftq_pkg and the frequency_table_query_engine RTL.
`timescale 1ns / 1ps

module frequency_table_query_engine_tb;
  import ftq_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int unsigned RANDOM_ITEMS   = 170;
  localparam int unsigned SAT_DRAIN      = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // An add or remove keeps the core busy in its read and write states after it is accepted.
  localparam int          END_SETTLE     = 12;

  // Both check encodings; code three behaves like code two.
  localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK_ALT = 2'd3;

  // One directed row; found is only meaningful when pinned is set.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [THR_W-1:0] thr;
    bit               pinned;
    bit               found;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_CHECK,     10'h3FF, 10'd0,    1'b1, 1'b0}, // empty table, threshold zero
    '{CMD_CHECK,     10'h000, 10'h3FF,  1'b1, 1'b0},
    '{CMD_REMOVE,    10'h000, 10'd0,    1'b0, 1'b0}, // remove at zero: ignored
    '{CMD_CHECK,     10'h000, 10'd0,    1'b1, 1'b0},
    '{CMD_ADD,       10'h000, 10'd0,    1'b0, 1'b0},
    '{CMD_CHECK,     10'h000, 10'd0,    1'b1, 1'b1},
    '{CMD_CHECK,     10'h000, 10'd1,    1'b1, 1'b1},
    '{CMD_CHECK,     10'h000, 10'd2,    1'b1, 1'b0},
    '{CMD_ADD,       10'h3FF, 10'h3FF,  1'b0, 1'b0},
    '{CMD_ADD,       10'h3FF, 10'd0,    1'b0, 1'b0}, // same key back to back
    '{CMD_CHECK,     10'h000, 10'd2,    1'b1, 1'b1},
    '{CMD_CHECK_ALT, 10'h000, 10'd2,    1'b1, 1'b1},
    '{CMD_CHECK_ALT, 10'h3FF, 10'd3,    1'b1, 1'b0},
    '{CMD_ADD,       10'h3FF, 10'd0,    1'b0, 1'b0},
    '{CMD_REMOVE,    10'h3FF, 10'd0,    1'b0, 1'b0},
    '{CMD_CHECK,     10'h000, 10'd3,    1'b1, 1'b0}, // largest dropped back to two
    '{CMD_CHECK,     10'h000, 10'h3FF,  1'b1, 1'b0},
    '{CMD_ADD,       10'h155, 10'h2AA,  1'b0, 1'b0},
    '{CMD_ADD,       10'h2AA, 10'h155,  1'b0, 1'b0},
    '{CMD_REMOVE,    10'h3FF, 10'h155,  1'b0, 1'b0},
    '{CMD_REMOVE,    10'h3FF, 10'h2AA,  1'b0, 1'b0},
    '{CMD_CHECK,     10'h155, 10'd2,    1'b1, 1'b0}, // every live key now holds one
    '{CMD_CHECK,     10'h2AA, 10'd1,    1'b1, 1'b1},
    '{CMD_REMOVE,    10'h000, 10'd0,    1'b0, 1'b0},
    '{CMD_REMOVE,    10'h155, 10'd0,    1'b0, 1'b0},
    '{CMD_REMOVE,    10'h2AA, 10'd0,    1'b0, 1'b0},
    '{CMD_CHECK,     10'h000, 10'd0,    1'b1, 1'b0}  // table empty again
  };

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // [1:0] command, [11:2] key, [21:12] threshold, [23:22] zero
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // [0] found, [7:1] zero
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  // Typed-in expectation travelling with the current input transaction.
  bit pin_en  = 1'b0;
  bit pin_val = 1'b0;

  // Predictor state: per-key counts, how many keys hold each count, and the peak.
  bit [COUNT_BITS-1:0] key_tally [KEY_SPACE];
  bit [KPC_BITS-1:0]   tally_population [COUNT_SPACE];
  bit [COUNT_BITS-1:0] peak_count;

  bit          pending_found [$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold  = 0;

  frequency_table_query_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Raise a key's count unless it already sits at the top count.
  function automatic void bump_count(input logic [KEY_W-1:0] k);
    bit [COUNT_BITS-1:0] c;
    c = key_tally[k];
    if (c == COUNT_TOP) return;
    if (c != 0) tally_population[c]--;
    c++;
    tally_population[c]++;
    key_tally[k] = c;
    if (c > peak_count) peak_count = c;
  endfunction

  // Lower a nonzero count; pull the peak down once nobody holds it any more.
  function automatic void drop_count(input logic [KEY_W-1:0] k);
    bit [COUNT_BITS-1:0] c;
    c = key_tally[k];
    if (c == 0) return;
    tally_population[c]--;
    if (c > 1) tally_population[c - 1'b1]++;
    key_tally[k] = c - 1'b1;
    if (c == peak_count && tally_population[c] == 0) peak_count = c - 1'b1;
  endfunction

  function automatic bit lookup_found(input logic [THR_W-1:0] thr);
    return (peak_count != 0) && (peak_count >= thr);
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one; none while steady.
  function automatic int unsigned next_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one input transaction at the falling edge and hold it until accepted.
  task automatic send_item(input ftq_in_t item, input bit pin, input bit pin_found,
                           input int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_TDATA_W'(item);
    pin_en          <= pin;
    pin_val         <= pin_found;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Hold off the sender until every outstanding check result has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_found.size() != 0) @(negedge clk_i);
  endtask

  // Pace the result side: short toggles, occasional long stalls, and long
  // always-ready stretches.
  always @(negedge clk_i) begin : result_pacing
    int unsigned r;
    if (ready_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        m_axis_tready_i <= 1'b1;
        ready_hold = $urandom_range(60, 200);
      end else if (r < 65) begin
        m_axis_tready_i <= 1'b1;
        ready_hold = $urandom_range(1, 4);
      end else if (r < 93) begin
        m_axis_tready_i <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        m_axis_tready_i <= 1'b0;
        ready_hold = $urandom_range(12, 40);
      end
    end else begin
      ready_hold--;
    end
  end

  // Update the predictor on every accepted command, then compare every
  // accepted result with the oldest outstanding expectation. Predicting
  // before checking keeps a same-edge enqueue and pop in order.
  always @(posedge clk_i) begin : scoreboard
    ftq_in_t taken;
    bit      in_fire;
    bit      out_fire;
    bit      want;
    if (rst_ni) begin
      in_fire  = s_axis_tvalid_i && s_axis_tready_o;
      out_fire = m_axis_tvalid_o && m_axis_tready_i;
      if (in_fire) begin
        taken = ftq_in_t'(s_axis_tdata_i[IN_BITS-1:0]);
        case (taken.command)
          CMD_ADD:    bump_count(taken.key);
          CMD_REMOVE: drop_count(taken.key);
          default: begin
            pending_found.insert(pending_found.size(),
                                 pin_en ? pin_val : lookup_found(taken.threshold));
          end
        endcase
      end
      if (out_fire) begin
        if (pending_found.size() == 0) begin
          $error("unexpected result transaction: found=%0d", m_axis_tdata_o[0]);
          fail_count++;
        end else begin
          want = pending_found.pop_front();
          if (m_axis_tdata_o[0] !== want) begin
            $error("found mismatch: expected %0d, actual %0d", want, m_axis_tdata_o[0]);
            fail_count++;
          end
          if (m_axis_tdata_o[M_TDATA_W-1:1] !== '0) begin
            $error("tdata pad mismatch: expected 0, actual 0x%0h",
                   m_axis_tdata_o[M_TDATA_W-1:1]);
            fail_count++;
          end
        end
      end
      // Covers the clearing pass after reset as well as stalls on either side.
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    ftq_in_t          item;
    logic [KEY_W-1:0] pool [6];
    logic [KEY_W-1:0] sat_key;
    int unsigned      sent;
    int unsigned      r;
    int unsigned      drained;
    int               t;
    bit               steady;
    bit               filling;

    sent    = 0;
    steady  = 1'b0;
    filling = 1'b1;
    foreach (pool[j]) pool[j] = KEY_W'($urandom_range(0, KEY_SPACE - 1));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, every command code, saturation-free corners.
    foreach (DIRECTED[i]) begin
      item.command   = DIRECTED[i].cmd;
      item.key       = DIRECTED[i].key;
      item.threshold = DIRECTED[i].thr;
      send_item(item, DIRECTED[i].pinned, DIRECTED[i].found, next_gap(1'b0));
    end
    wait_results_drained();

    // Random traffic: keys mostly from a small pool so counts build up and
    // same-key commands land back to back; alternate fill and drain phases.
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) begin
        steady  = ($urandom_range(0, 3) == 0);
        filling = !filling;
        if (filling) pool[$urandom_range(0, 5)] = KEY_W'($urandom_range(0, KEY_SPACE - 1));
      end
      if (sent == 60 || sent == 120) wait_results_drained();

      r = $urandom_range(0, 99);
      if (r < (filling ? 55 : 15))      item.command = CMD_ADD;
      else if (r < 70)                  item.command = CMD_REMOVE;
      else item.command = ($urandom_range(0, 1) != 0) ? CMD_CHECK_ALT : CMD_CHECK;

      item.key = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)]
                                             : KEY_W'($urandom_range(0, KEY_SPACE - 1));

      r = $urandom_range(0, 99);
      if (r < 60) begin
        // Probe just around the current peak, where found flips.
        t = int'(peak_count) + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > (1 << THR_W) - 1) t = (1 << THR_W) - 1;
        item.threshold = THR_W'(t);
      end else if (r < 75) begin
        item.threshold = '0;
      end else begin
        item.threshold = THR_W'($urandom_range(0, (1 << THR_W) - 1));
      end

      sent++;
      send_item(item, 1'b0, 1'b0, next_gap(steady));
    end

    // Drive one key to the top count and past it, then step it down a few
    // counts while probing the peak as it falls.
    sat_key        = KEY_W'($urandom_range(0, KEY_SPACE - 1));
    item.key       = sat_key;
    item.command   = CMD_ADD;
    item.threshold = '0;
    repeat (int'(COUNT_TOP) + 3) send_item(item, 1'b0, 1'b0, next_gap(1'b1));
    item.command   = CMD_CHECK;
    item.threshold = THR_W'(COUNT_TOP);
    send_item(item, 1'b0, 1'b0, next_gap(1'b0));

    drained = 0;
    while (drained < SAT_DRAIN) begin
      item.key       = sat_key;
      item.command   = CMD_REMOVE;
      send_item(item, 1'b0, 1'b0, next_gap(1'b0));
      drained++;
      item.command   = CMD_CHECK;
      item.threshold = THR_W'(peak_count + $urandom_range(0, 1));
      send_item(item, 1'b0, 1'b0, next_gap(1'b0));
    end
    item.command   = CMD_CHECK;
    item.threshold = '0;
    send_item(item, 1'b0, 1'b0, 0);

    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
